### sv/ast_pkg.sv
// Shared types and codes for the aging session table.
`timescale 1ns / 1ps
`default_nettype none

package ast_pkg;

  // Default table depth
  localparam int unsigned MAX_USERS_DEF = 16;

  // Command codes
  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_LOOKUP  = 3'd1;
  localparam logic [2:0] CMD_ALLOC   = 3'd2;
  localparam logic [2:0] CMD_SETCONN = 3'd3;
  localparam logic [2:0] CMD_TOUCH   = 3'd4;
  localparam logic [2:0] CMD_FLAGS   = 3'd5;
  localparam logic [2:0] CMD_QUERY   = 3'd6;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_SERVER_IP = 2'd0;
  localparam logic [1:0] CFG_NET_BITS  = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT   = 2'd2;

  // Configuration reset values
  localparam logic [31:0] SERVER_IP_RST = 32'd0;
  localparam logic [4:0]  NET_BITS_RST  = 5'd27;
  localparam logic [15:0] TIMEOUT_RST   = 16'd60;

  // One slot record as stored in the table memory
  typedef struct packed {
    logic        active;
    logic        authenticated;
    logic        disabled;
    logic        conn_dns;
    logic        queue_pending;
    logic [31:0] last_seen;
  } slot_rec_t;

endpackage

`default_nettype wire

### sv/ast_slot_mem.sv
// Slot record memory: one write port, one registered read port, per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none

module ast_slot_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX_W = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_en_i,
  input  logic [IDX_W-1:0]   rd_addr_i,
  output ast_pkg::slot_rec_t rd_data_o,
  input  logic               wr_en_i,
  input  logic [IDX_W-1:0]   wr_addr_i,
  input  ast_pkg::slot_rec_t wr_data_i
);
  import ast_pkg::*;

  slot_rec_t        mem [DEPTH];
  slot_rec_t        rd_q;
  logic             rd_vld_q;
  logic [DEPTH-1:0] vld_q;

  // Storage and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // Valid bits: an entry never written reads as all zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

### sv/aging_session_table_unit.sv
// Top level of the aging session table: command sequencer, config registers, result register.
`timescale 1ns / 1ps
`default_nettype none

// Session table of up to MAX_USERS client slots kept in one synchronous memory.
// An item is taken when start is high and busy is low; its result shows on the
// result ports for one cycle with done_o high and cannot be held off. Tick and
// rejected commands give their result the cycle after acceptance without raising
// busy. Set conn, touch and set flags do one read-modify-write of their slot:
// the slot is read on acceptance and written back in the modify state, whose
// result is registered. Lookup, allocate and query walk the slots in order
// through the memory's read port, one slot per cycle, and stop at the first
// hit or at the last slot; busy stays high through the scan. Configuration writes
// are always taken (cfg_ready_o is tied high) and must only happen while no
// item is in flight.

module aging_session_table_unit #(
  parameter int unsigned MAX_USERS = ast_pkg::MAX_USERS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd_i,
  input  logic [7:0]  user_id_i,
  input  logic [31:0] ip_i,
  input  logic [1:0]  conn_type_i,
  input  logic        flag_authenticated_i,
  input  logic        flag_disabled_i,
  input  logic        flag_queue_pending_i,
  // result channel
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [7:0]  slot_out_o,
  output logic [31:0] slot_ip_o,
  output logic        all_waiting_o,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import ast_pkg::*;

  localparam int unsigned IdxW = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
  localparam int unsigned CntW = $clog2(MAX_USERS + 1);
  localparam logic [9:0]  MaxU = 10'(MAX_USERS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_MOD  = 2'd2;

  // Configuration registers
  logic [31:0] server_ip_q;
  logic [4:0]  net_bits_q;
  logic [15:0] timeout_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      server_ip_q <= SERVER_IP_RST;
      net_bits_q  <= NET_BITS_RST;
      timeout_q   <= TIMEOUT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SERVER_IP: server_ip_q <= cfg_data_i;
        CFG_NET_BITS:  net_bits_q  <= cfg_data_i[4:0];
        CFG_TIMEOUT:   timeout_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Slot count: min(2^host_bits - 3, MAX_USERS), floored at zero
  logic [5:0]      host_bits;
  logic [9:0]      avail;
  logic [9:0]      n10;
  logic [CntW-1:0] n_slots;

  always_comb begin
    host_bits = 6'd32 - {1'b0, net_bits_q};
    avail     = (10'd1 << host_bits[3:0]) - 10'd3;
    if (host_bits < 6'd2) begin
      n10 = '0;
    end else if (host_bits > 6'd8 || avail >= MaxU) begin
      n10 = MaxU;
    end else begin
      n10 = avail;
    end
    n_slots = n10[CntW-1:0];
  end

  // Network base and the offset where the server address is skipped
  logic [31:0] base_d, base_q;
  logic [31:0] gap_d, gap_q;

  assign base_d = server_ip_q & (32'hFFFF_FFFF << host_bits);
  assign gap_d  = server_ip_q - base_d - 32'd1;

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    gap_q  <= gap_d;
  end

  // Sequencer state and latched item
  logic [1:0]      state_d, state_q;
  logic [IdxW-1:0] idx_d, idx_q;
  logic [2:0]      cmd_d, cmd_q;
  logic [31:0]     sec_d, sec_q;
  logic [31:0]     ip_q;
  logic            ct_q, fa_q, fd_q, fq_q;
  logic            accept;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      cmd_q   <= CMD_TICK;
      sec_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cmd_q   <= cmd_d;
      sec_q   <= sec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ip_q <= ip_i;
      ct_q <= conn_type_i[0];
      fa_q <= flag_authenticated_i;
      fd_q <= flag_disabled_i;
      fq_q <= flag_queue_pending_i;
    end
  end

  // Table memory
  logic            rd_en, wr_en;
  logic [IdxW-1:0] rd_addr;
  slot_rec_t       rd_rec, wr_rec;

  ast_slot_mem #(
    .DEPTH (MAX_USERS),
    .IDX_W (IdxW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_rec),
    .wr_en_i   (wr_en),
    .wr_addr_i (idx_q),
    .wr_data_i (wr_rec)
  );

  // Per-slot evaluation of the record read this cycle
  logic [31:0] cur_ip, age;
  logic        fresh, stale, last_slot, uid_bad;

  always_comb begin
    cur_ip    = base_q + 32'(idx_q) + 32'd1 + ((gap_q <= 32'(idx_q)) ? 32'd1 : 32'd0);
    age       = sec_q - rd_rec.last_seen;
    fresh     = age < {16'd0, timeout_q};
    stale     = age > {16'd0, timeout_q};
    last_slot = (CntW'(idx_q) + CntW'(1)) == n_slots;
    uid_bad   = {1'b0, user_id_i} >= 9'(n_slots);
  end

  // Command control
  logic        res_valid;
  logic [1:0]  res_status;
  logic [7:0]  res_slot;
  logic [31:0] res_ip;
  logic        res_wait;
  logic        hit;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cmd_d      = cmd_q;
    sec_d      = sec_q;
    rd_en      = 1'b0;
    rd_addr    = idx_q;
    wr_en      = 1'b0;
    wr_rec     = rd_rec;
    res_valid  = 1'b0;
    res_status = ST_OK;
    res_slot   = '0;
    res_ip     = '0;
    res_wait   = 1'b0;
    hit        = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d = cmd_i;
          case (cmd_i)
            CMD_TICK: begin
              sec_d     = sec_q + 32'd1;
              res_valid = 1'b1;
            end
            CMD_LOOKUP, CMD_ALLOC, CMD_QUERY: begin
              if (n_slots == '0) begin
                // empty table: nothing to scan
                res_valid  = 1'b1;
                res_status = (cmd_i == CMD_QUERY) ? ST_OK : ST_MISS;
                res_wait   = (cmd_i == CMD_QUERY);
              end else begin
                rd_en   = 1'b1;
                rd_addr = '0;
                idx_d   = '0;
                state_d = S_SCAN;
              end
            end
            CMD_SETCONN, CMD_TOUCH, CMD_FLAGS: begin
              if (uid_bad || (cmd_i == CMD_SETCONN && conn_type_i[1])) begin
                res_valid  = 1'b1;
                res_status = ST_BAD;
              end else begin
                rd_en   = 1'b1;
                rd_addr = user_id_i[IdxW-1:0];
                idx_d   = user_id_i[IdxW-1:0];
                state_d = S_MOD;
              end
            end
            default: begin
              res_valid  = 1'b1;
              res_status = ST_BAD;
            end
          endcase
        end
      end

      S_SCAN: begin
        case (cmd_q)
          CMD_LOOKUP: hit = rd_rec.active && rd_rec.authenticated && !rd_rec.disabled &&
                            fresh && (cur_ip == ip_q);
          CMD_ALLOC:  hit = (!rd_rec.active || stale) && !rd_rec.disabled;
          default:    hit = rd_rec.active && !rd_rec.disabled && fresh &&
                            (!rd_rec.conn_dns || !rd_rec.queue_pending);
        endcase
        if (hit) begin
          res_valid = 1'b1;
          state_d   = S_IDLE;
          if (cmd_q == CMD_QUERY) begin
            res_wait = 1'b0;
          end else begin
            res_slot = 8'(idx_q);
            res_ip   = cur_ip;
          end
          if (cmd_q == CMD_ALLOC) begin
            wr_en                = 1'b1;
            wr_rec.active        = 1'b1;
            wr_rec.authenticated = 1'b0;
            wr_rec.conn_dns      = 1'b1;
            wr_rec.last_seen     = sec_q;
          end
        end else if (last_slot) begin
          res_valid  = 1'b1;
          state_d    = S_IDLE;
          res_status = (cmd_q == CMD_QUERY) ? ST_OK : ST_MISS;
          res_wait   = (cmd_q == CMD_QUERY);
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_q + IdxW'(1);
          idx_d   = idx_q + IdxW'(1);
        end
      end

      S_MOD: begin
        // write back the modified slot record
        wr_en     = 1'b1;
        res_valid = 1'b1;
        state_d   = S_IDLE;
        case (cmd_q)
          CMD_SETCONN: wr_rec.conn_dns = ct_q;
          CMD_TOUCH:   wr_rec.last_seen = sec_q;
          default: begin
            wr_rec.authenticated = fa_q;
            wr_rec.disabled      = fd_q;
            wr_rec.queue_pending = fq_q;
          end
        endcase
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Result register
  logic        done_q;
  logic [1:0]  status_q;
  logic [7:0]  slot_q;
  logic [31:0] sip_q;
  logic        wait_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      status_q <= res_status;
      slot_q   <= res_slot;
      sip_q    <= res_ip;
      wait_q   <= res_wait;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign slot_out_o    = slot_q;
  assign slot_ip_o     = sip_q;
  assign all_waiting_o = wait_q;

`ifndef NO_ASSERTIONS
  // every accepted item either finishes next cycle or keeps the sequencer busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (done_o || busy))
    else $error("accepted item made no progress");

  // scan index never runs past the slot count
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (CntW'(idx_q) < n_slots))
    else $error("scan index beyond slot count");

  // a failed or rejected command reports no slot
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (slot_out_o == 8'd0 && slot_ip_o == 32'd0))
    else $error("slot reported with non-ok status");

  // the waiting flag is only ever set with an ok status
  a_wait_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && all_waiting_o) |-> (status_o == ST_OK))
    else $error("all_waiting with bad status");

  // the memory is written only while finishing an item
  a_write_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> done_o)
    else $error("table write without result");
`endif

endmodule

`default_nettype wire
